@@ hdl/nearest_waypoint_speed_command_unit_macros.svh @@
// Assertion macros for the nearest waypoint speed command unit.
// NWSC_ASSERT uses the clk and arst_n names of the module that includes this header.
`ifndef NEAREST_WAYPOINT_SPEED_COMMAND_UNIT_MACROS_SVH
`define NEAREST_WAYPOINT_SPEED_COMMAND_UNIT_MACROS_SVH
`ifndef SYNTH
`define NWSC_ASSERT_CLK(lbl, clk_i, rstn_i, prop, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) prop) else $error(msg);
`define NWSC_ASSERT(lbl, prop, msg) `NWSC_ASSERT_CLK(lbl, clk, arst_n, prop, msg)
`else
`define NWSC_ASSERT_CLK(lbl, clk_i, rstn_i, prop, msg)
`define NWSC_ASSERT(lbl, prop, msg)
`endif
`endif

@@ hdl/nwsc_pkg.sv @@
package nwsc_pkg;

	localparam int DEF_MAX_WAYPOINTS = 1024;

	localparam int POS_W      = 24;
	localparam int CURV_W     = 20;
	localparam int SPD_W      = 16;
	localparam int IDX_OUT_W  = 10;
	localparam int GAIN_W     = 16;
	localparam int VEL_W      = 15;
	localparam int THR_W      = 19;
	localparam int ACC_W      = 16;
	localparam int OPC_W      = 2;
	localparam int STAT_W     = 2;
	localparam int WP_W       = 2 * POS_W + CURV_W;
	localparam int SQ_W       = 2 * POS_W;
	localparam int DIST_W     = SQ_W + 1;
	localparam int ERR_W      = VEL_W + 3;
	localparam int PROD_W     = GAIN_W + 1 + ERR_W;
	localparam int SHIFT_W    = PROD_W - 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 19;
	localparam int IN_DATA_W  = 88;
	localparam int OUT_DATA_W = 32;

	// opcodes
	localparam logic [OPC_W-1:0] OP_LOAD  = 2'd0;
	localparam logic [OPC_W-1:0] OP_CLEAR = 2'd1;
	localparam logic [OPC_W-1:0] OP_QUERY = 2'd2;

	// result status
	localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ACCEL_GAIN   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CRUISE_SPEED = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CURVE_SPEED  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CURV_THRESH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ACCEL    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_DECEL    = 3'd5;

	// register reset values
	localparam logic [GAIN_W-1:0]        RST_ACCEL_GAIN   = 16'd768;
	localparam logic [VEL_W-1:0]         RST_CRUISE_SPEED = 15'd5120;
	localparam logic [VEL_W-1:0]         RST_CURVE_SPEED  = 15'd1280;
	localparam logic [THR_W-1:0]         RST_CURV_THRESH  = 19'd6554;
	localparam logic signed [ACC_W-1:0] RST_MAX_ACCEL    = 16'sd1280;
	localparam logic signed [ACC_W-1:0] RST_MAX_DECEL    = -16'sd768;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_KREAD,
		ST_KWAIT,
		ST_CMD,
		ST_DONE
	} nwsc_state_t;

	typedef struct packed {
		logic valid;
		logic last;
	} scan_tag_t;

	typedef struct packed {
		logic [GAIN_W-1:0]        accel_gain;
		logic [VEL_W-1:0]         cruise_speed;
		logic [VEL_W-1:0]         curve_speed;
		logic [THR_W-1:0]         curvature_threshold;
		logic signed [ACC_W-1:0] max_accel;
		logic signed [ACC_W-1:0] max_decel;
	} cfg_regs_t;

	typedef struct packed {
		logic                     done;
		logic                     on_curve;
		logic signed [ACC_W-1:0] accel;
	} cmd_res_t;

endpackage

@@ hdl/nearest_waypoint_speed_command_unit.sv @@
// Nearest waypoint speed command unit. Items arrive on the s_ stream with the opcode in
// s_tuser: load appends a waypoint (x, y, curvature) to a table of MAX_WAYPOINTS entries,
// clear empties it, query scans the table for the waypoint nearest to the vehicle position
// and returns its index plus a clamped acceleration command toward cruise or curve speed.
// Every item gives exactly one result on the m_ stream, status in m_tuser. A query on a
// non-empty table runs a scan loop that reads one waypoint per cycle through the single
// read port of the waypoint RAM into the shared distance and compare pipeline; load,
// clear, the unused opcode and a query on an empty table skip the scan. s_tready is low
// while an item is in progress. The result sits in an output register so the next item is
// taken while it waits. Registers are to be written through the cfg_ port only while the
// block is idle; the block itself does not enforce this, and cfg_ready is always high.
`include "nearest_waypoint_speed_command_unit_macros.svh"

module nearest_waypoint_speed_command_unit #(
	parameter int MAX_WAYPOINTS = nwsc_pkg::DEF_MAX_WAYPOINTS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// position_x[23:0], position_y[47:24], curvature[67:48], speed[83:68], zero fill
	input  logic [nwsc_pkg::IN_DATA_W-1:0]      s_tdata,
	// opcode[1:0]
	input  logic [nwsc_pkg::OPC_W-1:0]          s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// match_index[9:0], accel_command[25:10], on_curve[26], zero fill
	output logic [nwsc_pkg::OUT_DATA_W-1:0]     m_tdata,
	// status[1:0]
	output logic [nwsc_pkg::STAT_W-1:0]         m_tuser,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [nwsc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [nwsc_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int AW = $clog2(MAX_WAYPOINTS);
	localparam int CW = $clog2(MAX_WAYPOINTS + 1);
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_WAYPOINTS);
	localparam int PX0 = 0;
	localparam int PY0 = nwsc_pkg::POS_W;
	localparam int PK0 = 2 * nwsc_pkg::POS_W;
	localparam int PS0 = PK0 + nwsc_pkg::CURV_W;
	localparam int PAD_W = nwsc_pkg::OUT_DATA_W - nwsc_pkg::IDX_OUT_W - nwsc_pkg::ACC_W - 1;

	nwsc_pkg::nwsc_state_t state_q, state_d;
	nwsc_pkg::cfg_regs_t   cfg_q;
	nwsc_pkg::scan_tag_t   tag_q;
	nwsc_pkg::cmd_res_t    cmd_res;

	logic signed [nwsc_pkg::POS_W-1:0]  in_x, in_y, rd_x, rd_y;
	logic signed [nwsc_pkg::CURV_W-1:0] in_k, rd_k;
	logic signed [nwsc_pkg::SPD_W-1:0]  in_spd;
	logic signed [nwsc_pkg::POS_W-1:0]  px_q, py_q;
	logic signed [nwsc_pkg::SPD_W-1:0]  spd_q;

	logic [CW-1:0]              count_q;
	logic [AW-1:0]              scan_addr_q, idx_q, raddr, scan_match;
	logic [nwsc_pkg::WP_W-1:0]  rdata;
	logic                       in_fire, ram_we, scan_issue, scan_last, scan_done;
	logic                       cmd_start, out_load, has_room;

	logic [AW-1:0]                      res_match_q;
	logic signed [nwsc_pkg::ACC_W-1:0] res_accel_q;
	logic                               res_curve_q;
	logic [nwsc_pkg::STAT_W-1:0]        res_status_q;
	logic [AW+nwsc_pkg::IDX_OUT_W-1:0]  match_ext;

	logic                               out_valid_q;
	logic [nwsc_pkg::IDX_OUT_W-1:0]     out_match_q;
	logic signed [nwsc_pkg::ACC_W-1:0] out_accel_q;
	logic                               out_curve_q;
	logic [nwsc_pkg::STAT_W-1:0]        out_status_q;

	assign in_x   = s_tdata[PX0 +: nwsc_pkg::POS_W];
	assign in_y   = s_tdata[PY0 +: nwsc_pkg::POS_W];
	assign in_k   = s_tdata[PK0 +: nwsc_pkg::CURV_W];
	assign in_spd = s_tdata[PS0 +: nwsc_pkg::SPD_W];

	assign rd_x = rdata[PX0 +: nwsc_pkg::POS_W];
	assign rd_y = rdata[PY0 +: nwsc_pkg::POS_W];
	assign rd_k = rdata[PK0 +: nwsc_pkg::CURV_W];

	assign in_fire   = s_tvalid && s_tready;
	assign has_room  = count_q < MAX_CNT;
	assign ram_we    = in_fire && (s_tuser == nwsc_pkg::OP_LOAD) && has_room;
	assign scan_last = (CW'(scan_addr_q) + CW'(1)) == count_q;
	assign cfg_ready = 1'b1;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			nwsc_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					if ((s_tuser == nwsc_pkg::OP_QUERY) && (count_q != '0)) begin
						state_d = nwsc_pkg::ST_SCAN;
					end else begin
						state_d = nwsc_pkg::ST_DONE;
					end
				end
			end
			nwsc_pkg::ST_SCAN: begin
				if (scan_last) begin
					state_d = nwsc_pkg::ST_DRAIN;
				end
			end
			nwsc_pkg::ST_DRAIN: begin
				if (scan_done) begin
					state_d = nwsc_pkg::ST_KREAD;
				end
			end
			nwsc_pkg::ST_KREAD: begin
				state_d = nwsc_pkg::ST_KWAIT;
			end
			nwsc_pkg::ST_KWAIT: begin
				state_d = nwsc_pkg::ST_CMD;
			end
			nwsc_pkg::ST_CMD: begin
				if (cmd_res.done) begin
					state_d = nwsc_pkg::ST_DONE;
				end
			end
			nwsc_pkg::ST_DONE: begin
				if (!out_valid_q || m_tready) begin
					state_d = nwsc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = nwsc_pkg::ST_IDLE;
			end
		endcase
	end

	// state outputs
	always_comb begin
		s_tready   = 1'b0;
		scan_issue = 1'b0;
		cmd_start  = 1'b0;
		out_load   = 1'b0;
		raddr      = scan_match;
		case (state_q)
			nwsc_pkg::ST_IDLE: begin
				s_tready = 1'b1;
			end
			nwsc_pkg::ST_SCAN: begin
				scan_issue = 1'b1;
				raddr      = scan_addr_q;
			end
			nwsc_pkg::ST_KWAIT: begin
				cmd_start = 1'b1;
			end
			nwsc_pkg::ST_DONE: begin
				out_load = !out_valid_q || m_tready;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= nwsc_pkg::ST_IDLE;
			count_q     <= '0;
			scan_addr_q <= '0;
			tag_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			tag_q.valid <= scan_issue;
			tag_q.last  <= scan_issue && scan_last;
			if (scan_issue) begin
				scan_addr_q <= scan_addr_q + AW'(1);
			end else begin
				scan_addr_q <= '0;
			end
			if (ram_we) begin
				count_q <= count_q + CW'(1);
			end else if (in_fire && (s_tuser == nwsc_pkg::OP_CLEAR)) begin
				count_q <= '0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.accel_gain          <= nwsc_pkg::RST_ACCEL_GAIN;
			cfg_q.cruise_speed        <= nwsc_pkg::RST_CRUISE_SPEED;
			cfg_q.curve_speed         <= nwsc_pkg::RST_CURVE_SPEED;
			cfg_q.curvature_threshold <= nwsc_pkg::RST_CURV_THRESH;
			cfg_q.max_accel           <= nwsc_pkg::RST_MAX_ACCEL;
			cfg_q.max_decel           <= nwsc_pkg::RST_MAX_DECEL;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				nwsc_pkg::REG_ACCEL_GAIN: begin
					cfg_q.accel_gain <= cfg_data[nwsc_pkg::GAIN_W-1:0];
				end
				nwsc_pkg::REG_CRUISE_SPEED: begin
					cfg_q.cruise_speed <= cfg_data[nwsc_pkg::VEL_W-1:0];
				end
				nwsc_pkg::REG_CURVE_SPEED: begin
					cfg_q.curve_speed <= cfg_data[nwsc_pkg::VEL_W-1:0];
				end
				nwsc_pkg::REG_CURV_THRESH: begin
					cfg_q.curvature_threshold <= cfg_data[nwsc_pkg::THR_W-1:0];
				end
				nwsc_pkg::REG_MAX_ACCEL: begin
					cfg_q.max_accel <= cfg_data[nwsc_pkg::ACC_W-1:0];
				end
				nwsc_pkg::REG_MAX_DECEL: begin
					cfg_q.max_decel <= cfg_data[nwsc_pkg::ACC_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		idx_q <= scan_addr_q;
		if (in_fire) begin
			px_q         <= in_x;
			py_q         <= in_y;
			spd_q        <= in_spd;
			res_match_q  <= '0;
			res_accel_q  <= '0;
			res_curve_q  <= 1'b0;
			if ((s_tuser == nwsc_pkg::OP_LOAD) && !has_room) begin
				res_status_q <= nwsc_pkg::STATUS_FULL;
			end else if ((s_tuser == nwsc_pkg::OP_QUERY) && (count_q == '0)) begin
				res_status_q <= nwsc_pkg::STATUS_EMPTY;
			end else begin
				res_status_q <= nwsc_pkg::STATUS_OK;
			end
		end else if (cmd_res.done) begin
			res_match_q  <= scan_match;
			res_accel_q  <= cmd_res.accel;
			res_curve_q  <= cmd_res.on_curve;
			res_status_q <= nwsc_pkg::STATUS_OK;
		end
		if (out_load) begin
			out_match_q  <= match_ext[nwsc_pkg::IDX_OUT_W-1:0];
			out_accel_q  <= res_accel_q;
			out_curve_q  <= res_curve_q;
			out_status_q <= res_status_q;
		end
	end

	assign match_ext = {{nwsc_pkg::IDX_OUT_W{1'b0}}, res_match_q};

	nwsc_ram #(
		.WIDTH (nwsc_pkg::WP_W),
		.DEPTH (MAX_WAYPOINTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[AW-1:0]),
		.wdata ({in_k, in_y, in_x}),
		.raddr (raddr),
		.rdata (rdata)
	);

	nwsc_scan #(
		.AW (AW)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.tag    (tag_q),
		.idx    (idx_q),
		.wp_x   (rd_x),
		.wp_y   (rd_y),
		.px     (px_q),
		.py     (py_q),
		.done   (scan_done),
		.match  (scan_match)
	);

	nwsc_cmd u_cmd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd_start),
		.k      (rd_k),
		.spd    (spd_q),
		.cfg    (cfg_q),
		.res    (cmd_res)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{PAD_W{1'b0}}, out_curve_q, out_accel_q, out_match_q};
	assign m_tuser  = out_status_q;

	`NWSC_ASSERT(a_count_bound, count_q <= MAX_CNT, "waypoint count beyond capacity")
	`NWSC_ASSERT(a_scan_done_drain, scan_done |-> (state_q == nwsc_pkg::ST_DRAIN), "scan end outside drain")
	`NWSC_ASSERT(a_cmd_done_state, cmd_res.done |-> (state_q == nwsc_pkg::ST_CMD), "command result outside command state")
	`NWSC_ASSERT(a_query_scans, (in_fire && (s_tuser == nwsc_pkg::OP_QUERY) && (count_q != '0)) |=> (state_q == nwsc_pkg::ST_SCAN), "query on filled table did not start scan")

endmodule

@@ hdl/nwsc_ram.sv @@
module nwsc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ hdl/nwsc_scan.sv @@
module nwsc_scan #(
	parameter int AW = 10
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  nwsc_pkg::scan_tag_t                 tag,
	input  logic [AW-1:0]                       idx,
	input  logic signed [nwsc_pkg::POS_W-1:0]   wp_x,
	input  logic signed [nwsc_pkg::POS_W-1:0]   wp_y,
	input  logic signed [nwsc_pkg::POS_W-1:0]   px,
	input  logic signed [nwsc_pkg::POS_W-1:0]   py,
	output logic                                done,
	output logic [AW-1:0]                       match
);

	localparam int DW = nwsc_pkg::POS_W + 1;

	logic signed [DW-1:0] dx, dy;
	logic [DW-1:0]        adx, ady;

	nwsc_pkg::scan_tag_t tag_s1, tag_s2, tag_s3;
	logic [AW-1:0]       idx_s1, idx_s2, idx_s3;
	logic [nwsc_pkg::POS_W-1:0]  adx_s1, ady_s1;
	logic [nwsc_pkg::SQ_W-1:0]   sqx_s2, sqy_s2;
	logic [nwsc_pkg::DIST_W-1:0] sum_s3;
	logic [nwsc_pkg::DIST_W-1:0] best_q;
	logic [AW-1:0]               match_q;
	logic                        done_q;

	assign dx  = {wp_x[nwsc_pkg::POS_W-1], wp_x} - {px[nwsc_pkg::POS_W-1], px};
	assign dy  = {wp_y[nwsc_pkg::POS_W-1], wp_y} - {py[nwsc_pkg::POS_W-1], py};
	assign adx = dx[DW-1] ? (~dx + DW'(1)) : dx;
	assign ady = dy[DW-1] ? (~dy + DW'(1)) : dy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
			done_q <= 1'b0;
		end else begin
			tag_s1 <= tag;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			done_q <= tag_s3.valid && tag_s3.last;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx;
		adx_s1 <= adx[nwsc_pkg::POS_W-1:0];
		ady_s1 <= ady[nwsc_pkg::POS_W-1:0];
		idx_s2 <= idx_s1;
		sqx_s2 <= adx_s1 * adx_s1;
		sqy_s2 <= ady_s1 * ady_s1;
		idx_s3 <= idx_s2;
		sum_s3 <= {1'b0, sqx_s2} + {1'b0, sqy_s2};
		// entry zero seeds the search; strict compare keeps the earliest on a tie
		if (tag_s3.valid && ((idx_s3 == '0) || (sum_s3 < best_q))) begin
			best_q  <= sum_s3;
			match_q <= idx_s3;
		end
	end

	assign done  = done_q;
	assign match = match_q;

endmodule

@@ hdl/nwsc_cmd.sv @@
module nwsc_cmd (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [nwsc_pkg::CURV_W-1:0] k,
	input  logic signed [nwsc_pkg::SPD_W-1:0]  spd,
	input  nwsc_pkg::cfg_regs_t                cfg,
	output nwsc_pkg::cmd_res_t                 res
);

	localparam int EXT_W = nwsc_pkg::SHIFT_W - nwsc_pkg::ACC_W;

	logic [nwsc_pkg::CURV_W-1:0]       absk;
	logic                              curve;
	logic [nwsc_pkg::VEL_W-1:0]        target;
	logic signed [nwsc_pkg::ERR_W-1:0] err;
	logic signed [nwsc_pkg::SHIFT_W-1:0] acc, hi, lo;
	logic signed [nwsc_pkg::ACC_W-1:0]  clamped;

	logic                               valid_s1, valid_s2;
	logic                               curve_s1, curve_s2;
	logic signed [nwsc_pkg::ERR_W-1:0]  err_s1;
	logic signed [nwsc_pkg::PROD_W-1:0] prod_s2;
	nwsc_pkg::cmd_res_t                 res_q;

	assign absk   = k[nwsc_pkg::CURV_W-1] ? (~k + nwsc_pkg::CURV_W'(1)) : k;
	assign curve  = absk > {1'b0, cfg.curvature_threshold};
	assign target = curve ? cfg.curve_speed : cfg.cruise_speed;
	assign err    = $signed({3'b000, target}) - $signed({{2{spd[nwsc_pkg::SPD_W-1]}}, spd});

	// arithmetic shift by 8 rounds toward minus infinity
	assign acc = prod_s2[nwsc_pkg::PROD_W-1:8];
	assign hi  = {{EXT_W{cfg.max_accel[nwsc_pkg::ACC_W-1]}}, cfg.max_accel};
	assign lo  = {{EXT_W{cfg.max_decel[nwsc_pkg::ACC_W-1]}}, cfg.max_decel};

	always_comb begin
		if (acc > hi) begin
			clamped = cfg.max_accel;
		end else if (acc < lo) begin
			clamped = cfg.max_decel;
		end else begin
			clamped = acc[nwsc_pkg::ACC_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			res_q    <= '0;
		end else begin
			valid_s1       <= start;
			valid_s2       <= valid_s1;
			res_q.done     <= valid_s2;
			res_q.on_curve <= curve_s2;
			res_q.accel    <= clamped;
		end
	end

	always_ff @(posedge clk) begin
		curve_s1 <= curve;
		err_s1   <= err;
		curve_s2 <= curve_s1;
		prod_s2  <= $signed({1'b0, cfg.accel_gain}) * err_s1;
	end

	assign res = res_q;

endmodule

@@ dv/tb.sv @@
module tb;
	import nwsc_pkg::*;

	localparam int ROUTE_DEPTH = DEF_MAX_WAYPOINTS;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 400;
	localparam int PHASE_ITEMS = 110;
	localparam int MAX_PRINTS  = 100;

	localparam logic [OPC_W-1:0] OP_UNUSED = 2'd3;

	localparam int POS_MIN  = -(1 << (POS_W - 1));
	localparam int POS_MAX  = (1 << (POS_W - 1)) - 1;
	localparam int CURV_MIN = -(1 << (CURV_W - 1));
	localparam int CURV_MAX = (1 << (CURV_W - 1)) - 1;
	localparam int SPD_MIN  = -(1 << (SPD_W - 1));
	localparam int SPD_MAX  = (1 << (SPD_W - 1)) - 1;

	typedef struct packed {
		logic [OPC_W-1:0]         opcode;
		logic signed [POS_W-1:0]  pos_x;
		logic signed [POS_W-1:0]  pos_y;
		logic signed [CURV_W-1:0] curv;
		logic signed [SPD_W-1:0]  speed;
	} path_item_t;

	typedef struct packed {
		logic [IDX_OUT_W-1:0]    match_index;
		logic signed [ACC_W-1:0] accel_command;
		logic                    on_curve;
		logic [STAT_W-1:0]       status;
	} speed_cmd_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata   = '0;
	logic [OPC_W-1:0]      s_tuser   = '0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [STAT_W-1:0]     m_tuser;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	nearest_waypoint_speed_command_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	// predictor state: stored path and register copy
	logic signed [POS_W-1:0]  route_x [ROUTE_DEPTH];
	logic signed [POS_W-1:0]  route_y [ROUTE_DEPTH];
	logic signed [CURV_W-1:0] route_k [ROUTE_DEPTH];
	int route_len = 0;
	cfg_regs_t limits = '{accel_gain: RST_ACCEL_GAIN, cruise_speed: RST_CRUISE_SPEED,
		curve_speed: RST_CURVE_SPEED, curvature_threshold: RST_CURV_THRESH,
		max_accel: RST_MAX_ACCEL, max_decel: RST_MAX_DECEL};

	// stimulus side copy of what has been queued, used to aim queries at stored points
	logic signed [POS_W-1:0] plan_x [ROUTE_DEPTH];
	logic signed [POS_W-1:0] plan_y [ROUTE_DEPTH];
	int plan_len = 0;

	path_item_t path_items_todo[$];
	speed_cmd_t expected_cmds[$];
	path_item_t offered;

	int items_issued       = 0;
	int results_seen       = 0;
	int error_count        = 0;
	int cycle_count        = 0;
	int phase_count        = 0;
	int sender_idle_pct    = 0;
	int receiver_stall_pct = 0;
	int hold_left          = 0;
	bit hold_request       = 1'b0;
	bit item_taken         = 1'b0;

	task automatic log_mismatch(input string msg);
		error_count++;
		if (error_count <= MAX_PRINTS)
			$display("ERROR cycle %0d: %s", cycle_count, msg);
	endtask

	function automatic longint dist_sq(input logic signed [POS_W-1:0] ax, ay, bx, by);
		longint dx, dy;
		dx = longint'(ax) - longint'(bx);
		dy = longint'(ay) - longint'(by);
		return dx * dx + dy * dy;
	endfunction

	function automatic speed_cmd_t predict_speed_cmd(input path_item_t it);
		speed_cmd_t cmd;
		longint best, d, prod, acc;
		int pick, absk, target, err;
		cmd = '0;
		case (it.opcode)
			OP_LOAD: begin
				if (route_len < ROUTE_DEPTH) begin
					route_x[route_len] = it.pos_x;
					route_y[route_len] = it.pos_y;
					route_k[route_len] = it.curv;
					route_len++;
				end else
					cmd.status = STATUS_FULL;
			end
			OP_CLEAR: route_len = 0;
			OP_QUERY: begin
				if (route_len == 0)
					cmd.status = STATUS_EMPTY;
				else begin
					pick = 0;
					best = dist_sq(it.pos_x, it.pos_y, route_x[0], route_y[0]);
					// strict compare: the earliest waypoint keeps a tie
					for (int i = 1; i < route_len; i++) begin
						d = dist_sq(it.pos_x, it.pos_y, route_x[i], route_y[i]);
						if (d < best) begin
							best = d;
							pick = i;
						end
					end
					absk = int'($signed(route_k[pick]));
					if (absk < 0)
						absk = -absk;
					cmd.on_curve = absk > int'(limits.curvature_threshold);
					target = cmd.on_curve ? int'(limits.curve_speed) : int'(limits.cruise_speed);
					err = target - int'($signed(it.speed));
					prod = longint'(limits.accel_gain) * longint'(err);
					acc = prod >>> 8;
					// upper clamp wins when the limits are crossed
					if (acc > longint'($signed(limits.max_accel)))
						acc = longint'($signed(limits.max_accel));
					else if (acc < longint'($signed(limits.max_decel)))
						acc = longint'($signed(limits.max_decel));
					cmd.match_index = IDX_OUT_W'(pick);
					cmd.accel_command = ACC_W'(acc);
				end
			end
			default: ;
		endcase
		return cmd;
	endfunction

	function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		case (idx)
			REG_ACCEL_GAIN:   limits.accel_gain = value[GAIN_W-1:0];
			REG_CRUISE_SPEED: limits.cruise_speed = value[VEL_W-1:0];
			REG_CURVE_SPEED:  limits.curve_speed = value[VEL_W-1:0];
			REG_CURV_THRESH:  limits.curvature_threshold = value[THR_W-1:0];
			REG_MAX_ACCEL:    limits.max_accel = value[ACC_W-1:0];
			REG_MAX_DECEL:    limits.max_decel = value[ACC_W-1:0];
			default: ;
		endcase
	endfunction

	// accept side and result check, both on the rising edge
	always @(posedge clk) begin : result_check
		speed_cmd_t want;
		logic signed [ACC_W-1:0] got_accel;
		item_taken = 1'b0;
		if (arst_n) begin
			cycle_count++;
			if (cfg_valid && cfg_ready)
				apply_reg_write(cfg_index, cfg_data);
			if (s_tvalid && s_tready) begin
				item_taken = 1'b1;
				expected_cmds = {expected_cmds, predict_speed_cmd(offered)};
			end
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (expected_cmds.size() == 0)
					log_mismatch($sformatf("unexpected result tdata %h tuser %h", m_tdata, m_tuser));
				else begin
					want = expected_cmds.pop_front();
					got_accel = m_tdata[IDX_OUT_W +: ACC_W];
					if (m_tdata[IDX_OUT_W-1:0] !== want.match_index)
						log_mismatch($sformatf("result %0d match_index %0d, expected %0d",
							results_seen, m_tdata[IDX_OUT_W-1:0], want.match_index));
					if (got_accel !== want.accel_command)
						log_mismatch($sformatf("result %0d accel_command %0d, expected %0d",
							results_seen, got_accel, want.accel_command));
					if (m_tdata[IDX_OUT_W+ACC_W] !== want.on_curve)
						log_mismatch($sformatf("result %0d on_curve %b, expected %b",
							results_seen, m_tdata[IDX_OUT_W+ACC_W], want.on_curve));
					if (m_tuser !== want.status)
						log_mismatch($sformatf("result %0d status %0d, expected %0d",
							results_seen, m_tuser, want.status));
				end
			end
		end
	end

	always @(posedge clk) begin
		if (cycle_count > CYCLE_LIMIT) begin
			$display("ERROR: run stopped at %0d cycles", cycle_count);
			$display("Test completed with failures");
			$finish;
		end
	end

	// input driver: holds an offered item until its transaction, else maybe idles
	always @(negedge clk) begin : item_driver
		path_item_t it;
		logic next_valid;
		next_valid = s_tvalid && !item_taken;
		if (arst_n && !next_valid) begin
			if (path_items_todo.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
				it = path_items_todo.pop_front();
				items_issued++;
				offered <= it;
				s_tuser <= it.opcode;
				s_tdata <= {{(IN_DATA_W - WP_W - SPD_W){1'b0}}, it.speed, it.curv, it.pos_y, it.pos_x};
				next_valid = 1'b1;
			end
		end
		s_tvalid <= next_valid;
	end

	always @(negedge clk) begin
		if (hold_left > 0)
			hold_left--;
		else if (hold_request) begin
			hold_left = HOLD_CYCLES;
			hold_request = 1'b0;
		end
		m_tready <= (hold_left == 0) && ($urandom_range(99) >= receiver_stall_pct);
	end

	task automatic add_item(input logic [OPC_W-1:0] op, input int x, y, k, spd);
		path_item_t it;
		it.opcode = op;
		it.pos_x = POS_W'(x);
		it.pos_y = POS_W'(y);
		it.curv = CURV_W'(k);
		it.speed = SPD_W'(spd);
		path_items_todo = {path_items_todo, it};
		phase_count++;
		if (op == OP_CLEAR)
			plan_len = 0;
		else if (op == OP_LOAD && plan_len < ROUTE_DEPTH) begin
			plan_x[plan_len] = POS_W'(x);
			plan_y[plan_len] = POS_W'(y);
			plan_len++;
		end
	endtask

	task automatic wait_idle();
		while (path_items_todo.size() != 0 || results_seen < items_issued)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data <= value;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_limits(input int gain, cruise, curve, thr, amax, adec);
		write_reg(REG_ACCEL_GAIN, CFG_DATA_W'(gain));
		write_reg(REG_CRUISE_SPEED, CFG_DATA_W'(cruise));
		write_reg(REG_CURVE_SPEED, CFG_DATA_W'(curve));
		write_reg(REG_CURV_THRESH, CFG_DATA_W'(thr));
		write_reg(REG_MAX_ACCEL, CFG_DATA_W'(amax));
		write_reg(REG_MAX_DECEL, CFG_DATA_W'(adec));
	endtask

	// curvature spread over the full range and bunched around the live threshold
	function automatic logic signed [CURV_W-1:0] pick_curvature();
		int thr;
		thr = int'(limits.curvature_threshold);
		case ($urandom_range(3))
			0: return CURV_W'($urandom);
			1: return CURV_W'(($urandom_range(1) ? 1 : -1) * (thr + int'($urandom_range(1))));
			2: return CURV_W'(int'($urandom_range(2 * thr + 2)) - thr - 1);
			default: return CURV_W'($urandom_range(1) ? CURV_MIN : CURV_MAX);
		endcase
	endfunction

	function automatic logic signed [SPD_W-1:0] pick_speed();
		int target;
		target = $urandom_range(1) ? int'(limits.cruise_speed) : int'(limits.curve_speed);
		case ($urandom_range(3))
			0: return SPD_W'($urandom);
			1: return SPD_W'($urandom_range(1) ? SPD_MIN : SPD_MAX);
			default: return SPD_W'(target + int'($urandom_range(64)) - 32);
		endcase
	endfunction

	function automatic int pick_offset(input int spread);
		return int'($urandom_range(2 * spread)) - spread;
	endfunction

	// one path: usually clear, load a cluster of waypoints, then query around it
	task automatic queue_route_burst();
		int loads, a, b, spread, qx, qy;
		logic signed [POS_W-1:0] base_x, base_y;
		if ($urandom_range(9) == 0) begin
			repeat ($urandom_range(1, 3))
				add_item(OPC_W'($urandom_range(3)), $urandom, $urandom, $urandom, $urandom);
			return;
		end
		if (plan_len > 48 || $urandom_range(3) != 0)
			add_item(OP_CLEAR, $urandom, $urandom, $urandom, $urandom);
		base_x = $urandom_range(1) ? POS_W'($urandom) : '0;
		base_y = $urandom_range(1) ? POS_W'($urandom) : '0;
		spread = 1 << (4 * $urandom_range(1, 5));
		loads = ($urandom_range(7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
		repeat (loads) begin
			if (plan_len > 0 && $urandom_range(5) == 0) begin
				// duplicate point, so queries near it see a tie
				a = $urandom_range(plan_len - 1);
				add_item(OP_LOAD, int'(plan_x[a]), int'(plan_y[a]), int'(pick_curvature()),
					$urandom);
			end else
				add_item(OP_LOAD, base_x + pick_offset(spread), base_y + pick_offset(spread),
					int'(pick_curvature()), $urandom);
		end
		repeat ($urandom_range(1, 5)) begin
			a = $urandom_range(plan_len - 1);
			b = $urandom_range(plan_len - 1);
			case ($urandom_range(3))
				0: begin
					qx = int'(plan_x[a]);
					qy = int'(plan_y[a]);
				end
				1: begin
					qx = (int'(plan_x[a]) + int'(plan_x[b])) >>> 1;
					qy = (int'(plan_y[a]) + int'(plan_y[b])) >>> 1;
				end
				2: begin
					qx = base_x + pick_offset(spread);
					qy = base_y + pick_offset(spread);
				end
				default: begin
					qx = $urandom;
					qy = $urandom;
				end
			endcase
			add_item(OP_QUERY, qx, qy, $urandom, int'(pick_speed()));
		end
	endtask

	task automatic run_random(input int count);
		phase_count = 0;
		while (phase_count < count)
			queue_route_burst();
		wait_idle();
	endtask

	initial begin
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// directed: reset limits, no idling
		add_item(OP_QUERY, 0, 0, 0, 0);
		add_item(OP_UNUSED, -1, -1, -1, -1);
		add_item(OP_CLEAR, 0, 0, 0, 0);
		add_item(OP_LOAD, POS_MIN, POS_MAX, CURV_MIN, 0);
		add_item(OP_LOAD, POS_MAX, POS_MIN, CURV_MAX, 0);
		add_item(OP_LOAD, 0, 0, 6554, 0);
		add_item(OP_LOAD, 0, 0, CURV_MIN, 0);
		add_item(OP_LOAD, 100, -100, -6555, 0);
		add_item(OP_QUERY, POS_MAX, POS_MIN, 0, SPD_MIN);
		add_item(OP_QUERY, POS_MIN, POS_MAX, 0, SPD_MAX);
		add_item(OP_QUERY, 0, 0, 0, 5120);
		add_item(OP_QUERY, 1, -1, 0, 5130);
		add_item(OP_QUERY, 100, -100, 0, -1);
		add_item(OP_QUERY, POS_MIN, POS_MIN, -1, 0);
		add_item(OP_UNUSED, 0, 0, 0, 0);
		add_item(OP_QUERY, 100, -100, 0, 1280);
		add_item(OP_CLEAR, -1, -1, -1, -1);
		add_item(OP_QUERY, POS_MAX, POS_MAX, CURV_MAX, SPD_MAX);
		run_random(PHASE_ITEMS);

		set_limits(65535, 32767, 0, 0, 32767, -32768);
		sender_idle_pct = 86;
		run_random(PHASE_ITEMS);

		// crossed clamps with zero gain
		set_limits(0, 0, 32767, 524287, -32768, 32767);
		sender_idle_pct = 0;
		receiver_stall_pct = 86;
		run_random(PHASE_ITEMS);

		set_limits($urandom_range(65535), $urandom_range(32767), $urandom_range(32767),
			$urandom_range(524287), int'($urandom_range(65535)) - 32768,
			int'($urandom_range(65535)) - 32768);
		sender_idle_pct = 38;
		receiver_stall_pct = 38;
		run_random(PHASE_ITEMS);

		set_limits(1024, 7000, 2000, 30000, 2000, -2000);
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		hold_request = 1'b1;
		run_random(PHASE_ITEMS);

		repeat (40) @(negedge clk);
		if (expected_cmds.size() != 0)
			log_mismatch($sformatf("%0d expected results never arrived", expected_cmds.size()));
		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+hdl
hdl/nwsc_pkg.sv
hdl/nwsc_ram.sv
hdl/nwsc_scan.sv
hdl/nwsc_cmd.sv
hdl/nearest_waypoint_speed_command_unit.sv
dv/tb.sv
